// ===== src/rdct_pkg.sv =====
// Package for the reload down-counter timer: request kinds, register
// indexes, control bit positions and parameter defaults.
// No dependencies.
package rdct_pkg;

  localparam int COUNT_BITS_DEF    = 32;
  localparam int PRESCALE_BITS_DEF = 12;

  localparam int KIND_W = 2;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CTRL    = 3'd0,
    REG_STATUS  = 3'd1,
    REG_LOAD    = 3'd2,
    REG_COMPARE = 3'd3,
    REG_COUNT   = 3'd4,
    REG_RSVD5   = 3'd5,
    REG_RSVD6   = 3'd6,
    REG_RSVD7   = 3'd7
  } reg_idx_t;

  localparam int CTL_EN        = 0;
  localparam int CTL_LOAD_ON_EN = 1;
  localparam int CTL_CMP_IE    = 2;
  localparam int CTL_RELOAD    = 3;
  localparam int CTL_PRE_SHIFT = 4;
  localparam int CTL_OVERWRITE = 17;
  localparam int STS_MATCH     = 0;

endpackage

// ===== src/rdct_if.sv =====
// Valid/ready channel interfaces for timer requests and results.
// Depends on rdct_pkg for field widths.
interface rdct_in_if;
  logic                       valid;
  logic                       ready;
  logic [rdct_pkg::KIND_W-1:0] kind;
  logic [rdct_pkg::IDX_W-1:0]  reg_index;
  logic [rdct_pkg::DATA_W-1:0] write_data;

  modport source (output valid, kind, reg_index, write_data, input ready);
  modport sink   (input valid, kind, reg_index, write_data, output ready);
  modport monitor (input valid, ready, kind, reg_index, write_data);
endinterface

interface rdct_out_if;
  logic                       valid;
  logic                       ready;
  logic [rdct_pkg::DATA_W-1:0] read_data;
  logic                       compare_flag;
  logic                       irq;

  modport source (output valid, read_data, compare_flag, irq, input ready);
  modport sink   (input valid, read_data, compare_flag, irq, output ready);
  modport monitor (input valid, ready, read_data, compare_flag, irq);
endinterface

// ===== src/reload_down_counter_timer.sv =====
// Reload down-counter timer: register file, prescaler and counter.
// Depends on rdct_pkg and the channel interfaces in rdct_if.sv.
//
// Each request (tick, register read or register write) is taken into an
// input register, applied to the timer state in one pass of logic and
// answered through a result register. One request is accepted every clock
// cycle unless a stalled result holds it up; each result is presented once
// its request has passed the input and result registers. While a result
// waits at the output, one further request is still taken into the input
// register. The counter steps once every prescaler+1 enabled ticks and a
// step that lands on the compare value sets the status match flag.
module reload_down_counter_timer #(
  parameter int COUNT_BITS    = rdct_pkg::COUNT_BITS_DEF,
  parameter int PRESCALE_BITS = rdct_pkg::PRESCALE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rdct_in_if.sink           in_ch,
  rdct_out_if.source        out_ch
);

  logic                          s1_valid_r;
  logic [rdct_pkg::KIND_W-1:0]   s1_kind_r;
  logic [rdct_pkg::IDX_W-1:0]    s1_idx_r;
  logic [rdct_pkg::DATA_W-1:0]   s1_wdata_r;
  logic                          adv;

  logic [rdct_pkg::DATA_W-1:0]   ctl_r,   ctl_nxt;
  logic                          flag_r,  flag_nxt;
  logic [COUNT_BITS-1:0]         load_r,  load_nxt;
  logic [COUNT_BITS-1:0]         cmp_r,   cmp_nxt;
  logic [COUNT_BITS-1:0]         cnt_r,   cnt_nxt;
  logic [PRESCALE_BITS-1:0]      pre_r,   pre_nxt;

  logic                          out_valid_r;
  logic [rdct_pkg::DATA_W-1:0]   rdata_r, rdata_nxt;
  logic                          oflag_r;
  logic                          irq_r;

  logic [PRESCALE_BITS-1:0]      divider;
  logic [COUNT_BITS-1:0]         step_val;
  logic [COUNT_BITS-1:0]         wdata_cnt;
  logic [COUNT_BITS-1:0]         start_old;
  logic [COUNT_BITS-1:0]         start_new;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_kind_r  <= in_ch.kind;
      s1_idx_r   <= in_ch.reg_index;
      s1_wdata_r <= in_ch.write_data;
    end
  end

  assign divider   = ctl_r[rdct_pkg::CTL_PRE_SHIFT +: PRESCALE_BITS];
  assign start_old = ctl_r[rdct_pkg::CTL_RELOAD] ? load_r : {COUNT_BITS{1'b1}};
  assign start_new = s1_wdata_r[rdct_pkg::CTL_RELOAD] ? load_r : {COUNT_BITS{1'b1}};
  assign step_val  = (cnt_r == '0) ? start_old : cnt_r - COUNT_BITS'(1);
  assign wdata_cnt = COUNT_BITS'(s1_wdata_r);

  always_comb begin
    ctl_nxt   = ctl_r;
    flag_nxt  = flag_r;
    load_nxt  = load_r;
    cmp_nxt   = cmp_r;
    cnt_nxt   = cnt_r;
    pre_nxt   = pre_r;
    rdata_nxt = '0;
    case (rdct_pkg::kind_t'(s1_kind_r))
      rdct_pkg::KIND_TICK: begin
        if (ctl_r[rdct_pkg::CTL_EN]) begin
          if (pre_r != divider) begin
            pre_nxt = pre_r + PRESCALE_BITS'(1);
          end else begin
            pre_nxt = '0;
            cnt_nxt = step_val;
            if (step_val == cmp_r) flag_nxt = 1'b1;
          end
        end
      end
      rdct_pkg::KIND_READ: begin
        unique case (rdct_pkg::reg_idx_t'(s1_idx_r))
          rdct_pkg::REG_CTRL:    rdata_nxt = ctl_r;
          rdct_pkg::REG_STATUS:  rdata_nxt = rdct_pkg::DATA_W'(flag_r);
          rdct_pkg::REG_LOAD:    rdata_nxt = rdct_pkg::DATA_W'(load_r);
          rdct_pkg::REG_COMPARE: rdata_nxt = rdct_pkg::DATA_W'(cmp_r);
          rdct_pkg::REG_COUNT:   rdata_nxt = rdct_pkg::DATA_W'(cnt_r);
          default:               rdata_nxt = '0;
        endcase
      end
      rdct_pkg::KIND_WRITE: begin
        unique case (rdct_pkg::reg_idx_t'(s1_idx_r))
          rdct_pkg::REG_CTRL: begin
            ctl_nxt = s1_wdata_r;
            if (!ctl_r[rdct_pkg::CTL_EN] && s1_wdata_r[rdct_pkg::CTL_EN]) begin
              pre_nxt = '0;
              if (s1_wdata_r[rdct_pkg::CTL_LOAD_ON_EN]) cnt_nxt = start_new;
            end
          end
          rdct_pkg::REG_STATUS: begin
            if (s1_wdata_r[rdct_pkg::STS_MATCH]) flag_nxt = 1'b0;
          end
          rdct_pkg::REG_LOAD: begin
            load_nxt = wdata_cnt;
            if (ctl_r[rdct_pkg::CTL_OVERWRITE]) cnt_nxt = wdata_cnt;
          end
          rdct_pkg::REG_COMPARE: cmp_nxt = wdata_cnt;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      flag_r <= 1'b0;
      load_r <= '1;
      cmp_r  <= '0;
      cnt_r  <= '1;
      pre_r  <= '0;
    end else if (adv) begin
      ctl_r  <= ctl_nxt;
      flag_r <= flag_nxt;
      load_r <= load_nxt;
      cmp_r  <= cmp_nxt;
      cnt_r  <= cnt_nxt;
      pre_r  <= pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= rdata_nxt;
      oflag_r <= flag_nxt;
      irq_r   <= flag_nxt && ctl_nxt[rdct_pkg::CTL_CMP_IE] && ctl_nxt[rdct_pkg::CTL_EN];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = rdata_r;
  assign out_ch.compare_flag = oflag_r;
  assign out_ch.irq          = irq_r;

endmodule

// ===== src/rdct_checker.sv =====
// Port-level checks for the reload down-counter timer, bound to the top.
// Depends on the channel interfaces in rdct_if.sv.
module rdct_checker (
  input logic         clk,
  input logic         rst_n,
  rdct_in_if.sink     in_ch,
  rdct_out_if.source  out_ch
);

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  // interrupt level never without the match flag
  a_irq_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.irq || out_ch.compare_flag))
    else $error("irq without compare flag");

  // every accepted request leads to a valid result at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> ##2 out_ch.valid)
    else $error("no result after accepted request");

  // an empty output never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");

  // reset clears the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

bind reload_down_counter_timer rdct_checker u_rdct_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
